// ===== hdl/mda_pkg.sv =====
// Package for the morph delta accumulator.
// Holds the transfer structs, opcode and status codes, and default sizes.
// No dependencies.
package mda_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_UV_CHANNELS  = 4;

    localparam int OFS_W  = 24;
    localparam int WGT_W  = 16;
    localparam int ACC_W  = 32;
    localparam int VCNT_W = 13;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_ADD_POS = 3'd1;
    localparam logic [2:0] OP_ADD_UV  = 3'd2;
    localparam logic [2:0] OP_RD_POS  = 3'd3;
    localparam logic [2:0] OP_RD_UV   = 3'd4;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_BAD_VTX = 2'd1;
    localparam logic [1:0] STS_BAD_CH  = 2'd2;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [11:0]             vertex_index;
        logic [1:0]              channel;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic signed [OFS_W-1:0] offset_z;
        logic signed [OFS_W-1:0] offset_w;
        logic signed [WGT_W-1:0] weight;
    } item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    active;
        logic signed [ACC_W-1:0] delta_x;
        logic signed [ACC_W-1:0] delta_y;
        logic signed [ACC_W-1:0] delta_z;
        logic signed [ACC_W-1:0] delta_w;
    } result_t;

endpackage

// ===== hdl/mda_lane.sv =====
// One component lane: registered offset times weight product, rounding to
// Q16.16 and a saturating add onto the stored accumulator word.
// Depends on mda_pkg.
module mda_lane
    import mda_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic signed [OFS_W-1:0] offset,
    input  logic signed [WGT_W-1:0] weight,
    input  logic signed [ACC_W-1:0] acc,
    output logic signed [ACC_W-1:0] sum
);

    localparam int PRD_W = OFS_W + WGT_W;
    localparam int SCL_W = PRD_W - 14;

    logic signed [PRD_W-1:0] prod_reg;
    logic signed [PRD_W-1:0] rounded;
    logic signed [SCL_W-1:0] scaled;
    logic signed [ACC_W:0]   wide;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PRD_W'(offset) * PRD_W'(weight);
        end
    end

    // Adding half an LSB and dropping 14 bits rounds ties toward plus infinity.
    assign rounded = prod_reg + PRD_W'(8192);
    assign scaled  = rounded[PRD_W-1:14];
    assign wide    = {acc[ACC_W-1], acc} + (ACC_W+1)'(scaled);

    always_comb
    begin
        if (wide[ACC_W] != wide[ACC_W-1])
        begin
            sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum = wide[ACC_W-1:0];
        end
    end

endmodule

// ===== hdl/morph_delta_accumulator.sv =====
// Top level of the morph delta accumulator: position and uv stores, opcode
// decode, clearing sweep and result register.
// Depends on mda_pkg and mda_lane.
//
//  Channel  Signals                         Direction  Transfer
//  item     start, busy, item               in         start high while busy low
//  result   done, result                    out        done high for one cycle
//  config   cfg_valid, cfg_ready, cfg_data  in         cfg_valid and cfg_ready high
//
// For an item other than a clear, the store row is read when the item is accepted
// and written back in the EXEC state, when the result is loaded.
// A clear sweeps both stores one row a cycle up to the depth of the uv store,
// MAX_VERTICES * UV_CHANNELS rows, and then gives its result.
// After reset the same sweep runs before the first item is taken.
// Results cannot be stalled; busy alone paces the items.
module morph_delta_accumulator
    import mda_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int UV_CHANNELS  = DEF_UV_CHANNELS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [VCNT_W-1:0] cfg_data
);

    localparam int VAW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int UV_DEPTH = MAX_VERTICES * UV_CHANNELS;
    localparam int UAW      = (UV_DEPTH > 1) ? $clog2(UV_DEPTH) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [2:0][ACC_W-1:0] pos_mem [MAX_VERTICES];
    logic [3:0][ACC_W-1:0] uv_mem  [UV_DEPTH];

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [UAW-1:0]        clr_cnt_reg;
    logic                  clr_result_reg;
    logic                  active_reg;
    logic [VCNT_W-1:0]     vertex_count_reg;
    logic                  wr_pos_reg;
    logic                  wr_uv_reg;
    logic                  rd_pos_reg;
    logic                  rd_uv_reg;
    logic [1:0]            status_reg;
    logic [VAW-1:0]        pos_addr_reg;
    logic [UAW-1:0]        uv_addr_reg;
    logic [2:0][ACC_W-1:0] pos_rdata_reg;
    logic [3:0][ACC_W-1:0] uv_rdata_reg;
    logic                  done_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  accept;
    logic                  sweep_end;
    logic                  vtx_ok;
    logic                  ch_ok;
    logic [1:0]            status_dec;
    logic                  add_ok;
    logic                  is_uv_op;
    logic [VAW-1:0]        pos_addr;
    logic [UAW-1:0]        uv_addr;
    logic                  pos_we;
    logic                  uv_we;
    logic [VAW-1:0]        pos_waddr;
    logic [UAW-1:0]        uv_waddr;
    logic [2:0][ACC_W-1:0] pos_wdata;
    logic [3:0][ACC_W-1:0] uv_wdata;
    logic [3:0][ACC_W-1:0] acc_in;
    logic [3:0][ACC_W-1:0] lane_sum;
    logic [3:0][OFS_W-1:0] lane_ofs;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign sweep_end = (state_reg == ST_CLEAR) && (clr_cnt_reg == UAW'(UV_DEPTH - 1));

    assign vtx_ok   = ({1'b0, item.vertex_index} < vertex_count_reg)
                      && (int'(item.vertex_index) < MAX_VERTICES);
    assign ch_ok    = int'(item.channel) < UV_CHANNELS;
    assign is_uv_op = (item.opcode == OP_ADD_UV) || (item.opcode == OP_RD_UV);
    assign pos_addr = VAW'(item.vertex_index);
    assign uv_addr  = UAW'(UAW'(item.vertex_index) * UAW'(UV_CHANNELS) + UAW'(item.channel));

    always_comb
    begin
        status_dec = STS_OK;
        unique case (item.opcode) inside
            OP_ADD_POS, OP_ADD_UV, OP_RD_POS, OP_RD_UV:
            begin
                if (!vtx_ok)
                begin
                    status_dec = STS_BAD_VTX;
                end
                else if (is_uv_op && !ch_ok)
                begin
                    status_dec = STS_BAD_CH;
                end
            end
            default:
            begin
                status_dec = STS_OK;
            end
        endcase
    end

    assign add_ok = (status_dec == STS_OK) && (item.weight != '0)
                    && ((item.opcode == OP_ADD_POS) || (item.opcode == OP_ADD_UV));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.opcode == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            clr_result_reg   <= 1'b0;
            active_reg       <= 1'b0;
            vertex_count_reg <= '0;
            wr_pos_reg       <= 1'b0;
            wr_uv_reg        <= 1'b0;
            rd_pos_reg       <= 1'b0;
            rd_uv_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC) || (sweep_end && clr_result_reg);
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= sweep_end ? '0 : clr_cnt_reg + 1'b1;
                if (sweep_end)
                begin
                    clr_result_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                wr_pos_reg <= add_ok && (item.opcode == OP_ADD_POS);
                wr_uv_reg  <= add_ok && (item.opcode == OP_ADD_UV);
                rd_pos_reg <= (status_dec == STS_OK) && (item.opcode == OP_RD_POS);
                rd_uv_reg  <= (status_dec == STS_OK) && (item.opcode == OP_RD_UV);
                if (item.opcode == OP_CLEAR)
                begin
                    active_reg     <= 1'b0;
                    clr_result_reg <= 1'b1;
                end
                else if (add_ok)
                begin
                    active_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_dec;
            pos_addr_reg <= pos_addr;
            uv_addr_reg  <= uv_addr;
        end
        if (state_reg == ST_EXEC || (sweep_end && clr_result_reg))
        begin
            result_reg <= result_next;
        end
    end

    assign lane_ofs = {item.offset_w, item.offset_z, item.offset_y, item.offset_x};

    always_comb
    begin
        acc_in = wr_uv_reg ? uv_rdata_reg : {{ACC_W{1'b0}}, pos_rdata_reg};
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        mda_lane u_lane (
            .clk    (clk),
            .load   (accept),
            .offset (lane_ofs[c]),
            .weight (item.weight),
            .acc    (acc_in[c]),
            .sum    (lane_sum[c])
        );
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            pos_we    = (32'(clr_cnt_reg) < MAX_VERTICES);
            uv_we     = 1'b1;
            pos_waddr = clr_cnt_reg[VAW-1:0];
            uv_waddr  = clr_cnt_reg;
            pos_wdata = '0;
            uv_wdata  = '0;
        end
        else
        begin
            pos_we    = (state_reg == ST_EXEC) && wr_pos_reg;
            uv_we     = (state_reg == ST_EXEC) && wr_uv_reg;
            pos_waddr = pos_addr_reg;
            uv_waddr  = uv_addr_reg;
            pos_wdata = lane_sum[2:0];
            uv_wdata  = lane_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (accept)
        begin
            pos_rdata_reg <= pos_mem[pos_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (uv_we)
        begin
            uv_mem[uv_waddr] <= uv_wdata;
        end
        if (accept)
        begin
            uv_rdata_reg <= uv_mem[uv_addr];
        end
    end

    always_comb
    begin
        result_next         = '0;
        result_next.status  = (state_reg == ST_EXEC) ? status_reg : STS_OK;
        result_next.active  = (state_reg == ST_EXEC) ? active_reg : 1'b0;
        if (state_reg == ST_EXEC && rd_pos_reg)
        begin
            result_next.delta_x = pos_rdata_reg[0];
            result_next.delta_y = pos_rdata_reg[1];
            result_next.delta_z = pos_rdata_reg[2];
        end
        else if (state_reg == ST_EXEC && rd_uv_reg)
        begin
            result_next.delta_x = uv_rdata_reg[0];
            result_next.delta_y = uv_rdata_reg[1];
            result_next.delta_z = uv_rdata_reg[2];
            result_next.delta_w = uv_rdata_reg[3];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/mda_accum_checker.sv =====
// Result checker for the morph delta accumulator testbench.
// Watches the item, result and config transfers, predicts each result and compares it.
// Depends on mda_pkg.
`timescale 1ns / 1ps

module mda_accum_checker
    import mda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  item_t             item,
    input  logic              done,
    input  result_t           result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [VCNT_W-1:0] cfg_data,
    output int                fail_count,
    output int                open_count
);

    localparam int MAXV    = DEF_MAX_VERTICES;
    localparam int UVC     = DEF_UV_CHANNELS;
    localparam int UV_BASE = MAXV * 3;
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    int      delta_store [UV_BASE + MAXV * UVC * 4];
    bit      active_flag;
    int      vertex_count;
    result_t pending_results [$];

    function automatic int saturating_accumulate(input int acc,
                                                 input logic signed [OFS_W-1:0] ofs,
                                                 input logic signed [WGT_W-1:0] wgt);
        longint scaled;
        longint total;
        scaled = (longint'(ofs) * longint'(wgt) + 64'sd8192) >>> 14;
        total  = longint'(acc) + scaled;
        if (total > ACC_MAX)
            total = ACC_MAX;
        if (total < ACC_MIN)
            total = ACC_MIN;
        return int'(total);
    endfunction

    function automatic result_t predict_blend_result(input item_t it);
        result_t                 r;
        logic signed [OFS_W-1:0] ofs [4];
        int                      lim;
        int                      base;
        int                      n;
        bit                      is_uv;
        bit                      is_rd;
        r      = '0;
        ofs[0] = it.offset_x;
        ofs[1] = it.offset_y;
        ofs[2] = it.offset_z;
        ofs[3] = it.offset_w;
        lim    = (vertex_count < MAXV) ? vertex_count : MAXV;
        r.status = STS_OK;
        case (it.opcode)
            OP_CLEAR:
            begin
                foreach (delta_store[i])
                    delta_store[i] = 0;
                active_flag = 1'b0;
            end
            OP_ADD_POS, OP_ADD_UV, OP_RD_POS, OP_RD_UV:
            begin
                is_uv = (it.opcode == OP_ADD_UV) || (it.opcode == OP_RD_UV);
                is_rd = (it.opcode == OP_RD_POS) || (it.opcode == OP_RD_UV);
                n     = is_uv ? 4 : 3;
                base  = is_uv ? UV_BASE + (int'(it.vertex_index) * UVC + int'(it.channel)) * 4
                              : int'(it.vertex_index) * 3;
                if (int'(it.vertex_index) >= lim)
                    r.status = STS_BAD_VTX;
                else if (is_uv && int'(it.channel) >= UVC)
                    r.status = STS_BAD_CH;
                else if (is_rd)
                begin
                    r.delta_x = delta_store[base];
                    r.delta_y = delta_store[base + 1];
                    r.delta_z = delta_store[base + 2];
                    if (is_uv)
                        r.delta_w = delta_store[base + 3];
                end
                else if (it.weight != 0)
                begin
                    active_flag = 1'b1;
                    for (int c = 0; c < n; c++)
                        delta_store[base + c] =
                            saturating_accumulate(delta_store[base + c], ofs[c], it.weight);
                end
            end
            default:
            begin
            end
        endcase
        r.active = active_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            foreach (delta_store[i])
                delta_store[i] = 0;
            active_flag  = 1'b0;
            vertex_count = 0;
            pending_results.delete();
            fail_count = 0;
            open_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing expected: status %0d active %0d",
                                 $time, result.status, result.active);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status || result.active !== want.active ||
                        result.delta_x !== want.delta_x || result.delta_y !== want.delta_y ||
                        result.delta_z !== want.delta_z || result.delta_w !== want.delta_w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display(
                                "%0t: expected status %0d active %0d deltas %0d %0d %0d %0d",
                                $time, want.status, want.active, want.delta_x,
                                want.delta_y, want.delta_z, want.delta_w);
                            $display(
                                "%0t: got status %0d active %0d deltas %0d %0d %0d %0d",
                                $time, result.status, result.active, result.delta_x,
                                result.delta_y, result.delta_z, result.delta_w);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_results = {pending_results, predict_blend_result(item)};
            if (cfg_valid && cfg_ready)
                vertex_count = int'(cfg_data);
            open_count = pending_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the morph delta accumulator testbench: clock, reset, item and config stimulus.
// Depends on mda_pkg, morph_delta_accumulator and mda_accum_checker.
`timescale 1ns / 1ps

module tb
    import mda_pkg::*;
();

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASES        = 6;
    localparam int BURST_LEN     = 140;
    localparam int BURST_NONE    = 0;
    localparam int BURST_POS_UP  = 1;
    localparam int BURST_UV_DOWN = 2;
    localparam int OFS_TOP       = 2 ** (OFS_W - 1) - 1;
    localparam int OFS_BOTTOM    = -(2 ** (OFS_W - 1));
    localparam int WGT_TOP       = 2 ** (WGT_W - 1) - 1;
    localparam int WGT_BOTTOM    = -(2 ** (WGT_W - 1));

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              done;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [VCNT_W-1:0] cfg_data;
    int                fail_count;
    int                open_count;
    int                vertex_limit;
    int                cycles;

    morph_delta_accumulator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mda_accum_checker accum_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic item_t make_item(input logic [2:0] op, input int v, input int ch,
                                        input int x, input int y, input int z, input int w,
                                        input int wgt);
        item_t it;
        it.opcode       = op;
        it.vertex_index = 12'(v);
        it.channel      = 2'(ch);
        it.offset_x     = OFS_W'(x);
        it.offset_y     = OFS_W'(y);
        it.offset_z     = OFS_W'(z);
        it.offset_w     = OFS_W'(w);
        it.weight       = WGT_W'(wgt);
        return it;
    endfunction

    function automatic logic signed [OFS_W-1:0] random_offset();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return OFS_W'(OFS_TOP);
        if (pick == 1)
            return OFS_W'(OFS_BOTTOM);
        return OFS_W'($urandom);
    endfunction

    task automatic send_item(input item_t it, input int idle_pct);
        int gaps;
        gaps = 0;
        while (gaps < 20 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
            gaps++;
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_vertex_count(input int value);
        start <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= VCNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid    <= 1'b0;
        vertex_limit = (value < DEF_MAX_VERTICES) ? value : DEF_MAX_VERTICES;
    endtask

    initial
    begin
        item_t directed_items [$];
        item_t it;
        int    phase_vcount [PHASES];
        int    phase_idle   [PHASES];
        int    phase_len    [PHASES];
        int    phase_burst  [PHASES];
        int    r;
        int    v;
        int    clears_left;
        bit    neg_w;
        bit    off_max;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        vertex_limit = 0;

        phase_vcount = '{4096, 8191, 0, 1, 37, 4095};
        phase_idle   = '{0, 73, 37, 0, 37, 73};
        phase_len    = '{200, 120, 40, 80, 220, 100};
        phase_burst  = '{BURST_POS_UP, BURST_NONE, BURST_NONE, BURST_NONE, BURST_UV_DOWN,
                         BURST_NONE};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_vertex_count(8);
        directed_items = {directed_items, make_item(OP_RD_POS, 0, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items,
                          make_item(OP_ADD_POS, 0, 0, OFS_TOP, OFS_BOTTOM, 12345, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_POS, 0, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items,
                          make_item(OP_ADD_POS, 0, 0, OFS_TOP, OFS_BOTTOM, -1, 0, WGT_TOP)};
        directed_items = {directed_items,
                          make_item(OP_ADD_POS, 0, 0, OFS_BOTTOM, OFS_TOP, 1, 0, WGT_BOTTOM)};
        directed_items = {directed_items,
                          make_item(OP_ADD_UV, 1, 3, 8192, -8192, -8193, 1, 1)};
        directed_items = {directed_items,
                          make_item(OP_ADD_UV, 1, 0, OFS_TOP, OFS_BOTTOM, OFS_TOP,
                                    OFS_BOTTOM, -1)};
        directed_items = {directed_items, make_item(OP_RD_UV, 1, 3, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_UV, 1, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_POS, 0, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items,
                          make_item(OP_ADD_POS, 7, 2, 4660, -4660, 100, 0, 16384)};
        directed_items = {directed_items, make_item(OP_RD_POS, 7, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items,
                          make_item(OP_ADD_POS, 8, 1, 4660, -4660, 100, 0, 16384)};
        directed_items = {directed_items, make_item(OP_RD_UV, 4095, 2, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_POS, 8, 0, 0, 0, 0, 0, 0)};
        for (int k = 1; k <= 3; k++)
            directed_items = {directed_items,
                              make_item(3'(OP_RD_UV + 3'(k)), k, k, -k, k, -k, k, 99)};
        directed_items = {directed_items, make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_POS, 0, 0, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_RD_UV, 1, 3, 0, 0, 0, 0, 0)};
        directed_items = {directed_items, make_item(OP_ADD_UV, 7, 3, -1, -1, -1, -1, -1)};
        directed_items = {directed_items, make_item(OP_RD_UV, 7, 3, 0, 0, 0, 0, 0)};
        foreach (directed_items[k])
            send_item(directed_items[k], 37);

        for (int p = 0; p < PHASES; p++)
        begin
            write_vertex_count(phase_vcount[p]);
            clears_left = 3;
            for (int k = 0; k < phase_len[p]; k++)
            begin
                if (phase_burst[p] != BURST_NONE && k < BURST_LEN)
                begin
                    neg_w   = 1'($urandom_range(1));
                    off_max = neg_w ^ (phase_burst[p] == BURST_POS_UP);
                    it.vertex_index = (phase_burst[p] == BURST_POS_UP) ? 12'd1 : 12'd2;
                    it.channel      = 2'd3;
                    it.weight       = WGT_W'(neg_w ? WGT_BOTTOM : WGT_TOP);
                    it.offset_x     = OFS_W'(off_max ? OFS_TOP - $urandom_range(255)
                                                     : OFS_BOTTOM + $urandom_range(255));
                    it.offset_y     = OFS_W'(off_max ? OFS_TOP - $urandom_range(255)
                                                     : OFS_BOTTOM + $urandom_range(255));
                    it.offset_z     = OFS_W'(off_max ? OFS_TOP - $urandom_range(255)
                                                     : OFS_BOTTOM + $urandom_range(255));
                    it.offset_w     = OFS_W'(off_max ? OFS_TOP - $urandom_range(255)
                                                     : OFS_BOTTOM + $urandom_range(255));
                    if (phase_burst[p] == BURST_POS_UP)
                        it.opcode = (k % 16 == 15) ? OP_RD_POS : OP_ADD_POS;
                    else
                        it.opcode = (k % 16 == 15) ? OP_RD_UV : OP_ADD_UV;
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 2)
                    begin
                        it.opcode = (clears_left > 0) ? OP_CLEAR : OP_ADD_POS;
                        if (clears_left > 0)
                            clears_left--;
                    end
                    else if (r < 42)
                        it.opcode = OP_ADD_POS;
                    else if (r < 72)
                        it.opcode = OP_ADD_UV;
                    else if (r < 84)
                        it.opcode = OP_RD_POS;
                    else if (r < 96)
                        it.opcode = OP_RD_UV;
                    else
                        it.opcode = 3'(OP_RD_UV + 3'($urandom_range(1, 3)));

                    if ($urandom_range(99) < 30)
                        v = $urandom_range(DEF_MAX_VERTICES - 1);
                    else
                    begin
                        v = $urandom_range(5);
                        if (v >= 4)
                            v = vertex_limit - 5 + v;
                        if (v < 0)
                            v = 0;
                        if (v > DEF_MAX_VERTICES - 1)
                            v = DEF_MAX_VERTICES - 1;
                    end
                    it.vertex_index = 12'(v);
                    it.channel      = 2'($urandom);
                    it.offset_x     = random_offset();
                    it.offset_y     = random_offset();
                    it.offset_z     = random_offset();
                    it.offset_w     = random_offset();
                    r = $urandom_range(99);
                    if (r < 10)
                        it.weight = '0;
                    else if (r < 20)
                        it.weight = WGT_W'(WGT_TOP);
                    else if (r < 30)
                        it.weight = WGT_W'(WGT_BOTTOM);
                    else
                        it.weight = WGT_W'($urandom);
                end
                send_item(it, phase_idle[p]);
            end
        end

        start <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
